@@ rtl/core/climate_zone_controller_pid_defines.svh @@
// Assertion macros used by the checker of the climate zone controller.
`ifndef CLIMATE_ZONE_CONTROLLER_PID_DEFINES_SVH
`define CLIMATE_ZONE_CONTROLLER_PID_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CZC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("czc check failed");

// Next-cycle implication, ignored while reset is asserted.
`define CZC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("czc check failed");

// Next-cycle implication that also holds through reset.
`define CZC_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("czc check failed");

`endif

@@ rtl/core/czc_pkg.sv @@
package czc_pkg;

  typedef struct packed {
    logic [6:0] temp_a;
    logic [6:0] temp_b;
    logic [6:0] hum_a;
    logic [6:0] hum_b;
    logic       valid_a;
    logic       valid_b;
    logic [9:0] water_adc;
  } czc_in_t;

  typedef struct packed {
    logic        fan_on;
    logic        bulb_on;
    logic        humidifier_on;
    logic [10:0] duty_level;
    logic        tank_low;
    logic [7:0]  temp_sum;
    logic [7:0]  hum_sum;
  } czc_out_t;

  typedef struct packed {
    logic       control_mode;
    logic [6:0] humidity_target;
    logic       manual_fan;
    logic       manual_bulb;
    logic       manual_humidifier;
    logic [6:0] hot_limit;
    logic [6:0] dry_limit;
    logic [6:0] wet_limit;
  } czc_cfg_t;

  typedef struct packed {
    logic fan;
    logic bulb;
    logic hum;
  } czc_act_t;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_MODE      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUMIDITY_TARGET   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_FAN        = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_BULB       = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_HUMIDIFIER = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOT_LIMIT         = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRY_LIMIT         = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_WET_LIMIT         = 4'd7;

  localparam logic [6:0] HUMIDITY_TARGET_RESET = 7'd75;
  localparam logic [6:0] HOT_LIMIT_RESET       = 7'd40;
  localparam logic [6:0] DRY_LIMIT_RESET       = 7'd70;
  localparam logic [6:0] WET_LIMIT_RESET       = 7'd80;

  localparam logic [6:0] TEMP_A_RESET = 7'd20;
  localparam logic [6:0] TEMP_B_RESET = 7'd21;
  localparam logic [6:0] HUM_RESET    = 7'd0;

  localparam logic [10:0] INTEGRAL_MAX = 11'd2000;
  localparam logic [10:0] DUTY_FULL    = 11'd1024;
  localparam logic [10:0] DUTY_RESET   = 11'd409;
  localparam logic [9:0]  TANK_ALARM_CODE = 10'd286;

  // Duty is n * 32 / 125; at n of 4000 or more it saturates at full scale.
  localparam logic signed [14:0] DUTY_SAT_N  = 15'sd4000;
  localparam logic [17:0]        DUTY_RECIP  = 18'd134218;
  localparam int unsigned        DUTY_SHIFT  = 24;

endpackage

@@ rtl/core/czc_cfg_regs.sv @@
module czc_cfg_regs
  import czc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output czc_cfg_t               cfg
);

  czc_cfg_t cfg_r;
  czc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTROL_MODE:      cfg_nxt.control_mode      = cfg_wdata[0];
        CFG_HUMIDITY_TARGET:   cfg_nxt.humidity_target   = cfg_wdata;
        CFG_MANUAL_FAN:        cfg_nxt.manual_fan        = cfg_wdata[0];
        CFG_MANUAL_BULB:       cfg_nxt.manual_bulb       = cfg_wdata[0];
        CFG_MANUAL_HUMIDIFIER: cfg_nxt.manual_humidifier = cfg_wdata[0];
        CFG_HOT_LIMIT:         cfg_nxt.hot_limit         = cfg_wdata;
        CFG_DRY_LIMIT:         cfg_nxt.dry_limit         = cfg_wdata;
        CFG_WET_LIMIT:         cfg_nxt.wet_limit         = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_mode      <= 1'b0;
      cfg_r.humidity_target   <= HUMIDITY_TARGET_RESET;
      cfg_r.manual_fan        <= 1'b0;
      cfg_r.manual_bulb       <= 1'b0;
      cfg_r.manual_humidifier <= 1'b0;
      cfg_r.hot_limit         <= HOT_LIMIT_RESET;
      cfg_r.dry_limit         <= DRY_LIMIT_RESET;
      cfg_r.wet_limit         <= WET_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/czc_readings.sv @@
module czc_readings
  import czc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  czc_in_t    in_word,
  output logic [7:0] temp_sum,
  output logic [7:0] hum_sum
);

  logic [6:0] temp_a_r, temp_b_r, hum_a_r, hum_b_r;
  logic [6:0] temp_a_nxt, temp_b_nxt, hum_a_nxt, hum_b_nxt;

  // A sensor flagged bad leaves its last good pair in place.
  always_comb begin
    temp_a_nxt = in_word.valid_a ? in_word.temp_a : temp_a_r;
    hum_a_nxt  = in_word.valid_a ? in_word.hum_a  : hum_a_r;
    temp_b_nxt = in_word.valid_b ? in_word.temp_b : temp_b_r;
    hum_b_nxt  = in_word.valid_b ? in_word.hum_b  : hum_b_r;
  end

  assign temp_sum = {1'b0, temp_a_nxt} + {1'b0, temp_b_nxt};
  assign hum_sum  = {1'b0, hum_a_nxt} + {1'b0, hum_b_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_a_r <= TEMP_A_RESET;
      temp_b_r <= TEMP_B_RESET;
      hum_a_r  <= HUM_RESET;
      hum_b_r  <= HUM_RESET;
    end else if (upd) begin
      temp_a_r <= temp_a_nxt;
      temp_b_r <= temp_b_nxt;
      hum_a_r  <= hum_a_nxt;
      hum_b_r  <= hum_b_nxt;
    end
  end

endmodule

@@ rtl/core/czc_decide.sv @@
module czc_decide
  import czc_pkg::*;
(
  input  czc_cfg_t   cfg,
  input  logic [7:0] temp_sum,
  input  logic [7:0] hum_sum,
  output czc_act_t   act
);

  logic hot, dry, wet;

  assign hot = temp_sum > {cfg.hot_limit, 1'b0};
  assign dry = hum_sum  < {cfg.dry_limit, 1'b0};
  assign wet = hum_sum  > {cfg.wet_limit, 1'b0};

  always_comb begin
    act = '0;
    if (cfg.control_mode) begin
      act.fan  = cfg.manual_fan;
      act.bulb = cfg.manual_bulb;
      act.hum  = cfg.manual_humidifier;
    end else if (hot) begin
      act.fan = 1'b1;
      act.hum = dry;
    end else if (dry) begin
      act.hum = 1'b1;
    end else if (!wet) begin
      act.fan = 1'b1;
    end else begin
      act.bulb = 1'b1;
    end
  end

endmodule

@@ rtl/core/czc_pid.sv @@
module czc_pid
  import czc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        hum_on,
  input  logic [6:0]  target,
  input  logic [7:0]  hum_sum,
  output logic [10:0] duty
);

  logic [10:0]        integ_r, integ_nxt;
  logic signed [8:0]  prev_err_r;
  logic [10:0]        duty_r, duty_calc;

  logic signed [8:0]  err;
  logic signed [12:0] isum;
  logic signed [9:0]  deriv;
  logic signed [14:0] err15;
  logic signed [14:0] n;
  logic [16:0]        scaled;
  logic [34:0]        prod;

  // Error in half-percent: twice the setpoint against the sum of two readings.
  assign err = $signed({1'b0, target, 1'b0}) - $signed({1'b0, hum_sum});

  assign isum = $signed({2'b00, integ_r}) + 13'(err);

  always_comb begin
    if (isum < 13'sd0) begin
      integ_nxt = '0;
    end else if (isum > $signed({2'b00, INTEGRAL_MAX})) begin
      integ_nxt = INTEGRAL_MAX;
    end else begin
      integ_nxt = isum[10:0];
    end
  end

  assign deriv  = 10'(err) - 10'(prev_err_r);
  assign err15  = 15'(err);
  assign n      = (err15 <<< 4) + (err15 <<< 2) + $signed({3'b000, integ_nxt, 1'b0})
                  + 15'(deriv);
  assign scaled = {n[11:0], 5'b00000};
  assign prod   = 35'(scaled) * 35'(DUTY_RECIP);

  always_comb begin
    if (n <= 15'sd0) begin
      duty_calc = '0;
    end else if (n >= DUTY_SAT_N) begin
      duty_calc = DUTY_FULL;
    end else begin
      duty_calc = prod[DUTY_SHIFT +: 11];
    end
  end

  assign duty = hum_on ? duty_calc : duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
      duty_r     <= DUTY_RESET;
    end else if (step && hum_on) begin
      integ_r    <= integ_nxt;
      prev_err_r <= err;
      duty_r     <= duty_calc;
    end
  end

endmodule

@@ rtl/core/climate_zone_controller_pid.sv @@
// Climate zone controller with a PID-driven humidifier duty.
// The input channel (in_valid, in_ready, in_data) takes one sampling tick per
// word: two temperature and humidity pairs with validity flags and a water
// level code. The result channel (out_valid, out_ready, out_data) returns one
// word per tick with actuator enables, the duty, the tank alarm and the sums.
// Registers are written through cfg_we, cfg_index and cfg_wdata; the user must
// write them only while idle, as the block does not enforce it. A word is
// registered on acceptance; its result is loaded into the output register once
// that register is free, raising out_valid. One word is accepted every cycle
// while out_ready is high; the kept readings and, with the humidifier on, the
// PID state update in the same cycle that the result is registered.
// While the receiver stalls, the output word holds and one further word can
// wait in the input register; in_ready falls only when both are full.
// Reset is synchronous: it empties both stages and restores the registers,
// the kept readings, the integral, the previous error and the held duty.
module climate_zone_controller_pid
  import czc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  czc_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output czc_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic     in_v_r;
  czc_in_t  in_word_r;
  logic     out_v_r;
  czc_out_t out_word_r, out_word_nxt;
  logic     advance, fire;

  czc_cfg_t    cfg;
  czc_act_t    act;
  logic [7:0]  temp_sum, hum_sum;
  logic [10:0] duty;

  assign advance  = !out_v_r || out_ready;
  assign fire     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  czc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  czc_readings u_readings (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (fire),
    .in_word  (in_word_r),
    .temp_sum (temp_sum),
    .hum_sum  (hum_sum)
  );

  czc_decide u_decide (
    .cfg      (cfg),
    .temp_sum (temp_sum),
    .hum_sum  (hum_sum),
    .act      (act)
  );

  czc_pid u_pid (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (fire),
    .hum_on  (act.hum),
    .target  (cfg.humidity_target),
    .hum_sum (hum_sum),
    .duty    (duty)
  );

  always_comb begin
    out_word_nxt.fan_on        = act.fan;
    out_word_nxt.bulb_on       = act.bulb;
    out_word_nxt.humidifier_on = act.hum;
    out_word_nxt.duty_level    = duty;
    out_word_nxt.tank_low      = in_word_r.water_adc <= TANK_ALARM_CODE;
    out_word_nxt.temp_sum      = temp_sum;
    out_word_nxt.hum_sum       = hum_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
    if (fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

endmodule

@@ rtl/core/czc_checker.sv @@
`include "climate_zone_controller_pid_defines.svh"

module czc_checker
  import czc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input czc_out_t out_data
);

  `CZC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CZC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `CZC_ASSERT_NOW(a_duty_range, clk, rst_n, out_valid, out_data.duty_level <= DUTY_FULL)
  `CZC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind climate_zone_controller_pid czc_checker u_czc_checker (.*);

@@ sim/tb_climate_zone_controller_pid.sv @@
module tb_climate_zone_controller_pid;
  import czc_pkg::*;

  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 125;
  localparam int HOLD_CYCLES     = 120;
  localparam int QUIET_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 8;

  class zone_outcome_book;
    czc_cfg_t    regs;
    logic [6:0]  kept_temp [2];
    logic [6:0]  kept_hum [2];
    int          integral;
    int          last_err;
    logic [10:0] duty;
    czc_out_t    due [$];
    int          faults;
    int          checked;
    int          loop_runs;
    int          full_duty;
    int          zero_duty;
    int          tank_alarms;

    function new();
      regs = {1'b0, HUMIDITY_TARGET_RESET, 3'b000, HOT_LIMIT_RESET, DRY_LIMIT_RESET,
              WET_LIMIT_RESET};
      kept_temp[0] = TEMP_A_RESET;
      kept_temp[1] = TEMP_B_RESET;
      kept_hum[0]  = HUM_RESET;
      kept_hum[1]  = HUM_RESET;
      integral     = 0;
      last_err     = 0;
      duty         = DUTY_RESET;
      faults       = 0;
      checked      = 0;
      loop_runs    = 0;
      full_duty    = 0;
      zero_duty    = 0;
      tank_alarms  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_CONTROL_MODE:      regs.control_mode      = data[0];
        CFG_HUMIDITY_TARGET:   regs.humidity_target   = data;
        CFG_MANUAL_FAN:        regs.manual_fan        = data[0];
        CFG_MANUAL_BULB:       regs.manual_bulb       = data[0];
        CFG_MANUAL_HUMIDIFIER: regs.manual_humidifier = data[0];
        CFG_HOT_LIMIT:         regs.hot_limit         = data;
        CFG_DRY_LIMIT:         regs.dry_limit         = data;
        CFG_WET_LIMIT:         regs.wet_limit         = data;
        default: ;
      endcase
    endfunction

    function void take_sample(czc_in_t w);
      czc_out_t r;
      int       tsum;
      int       hsum;
      int       e;
      int       d;
      int       n;
      int       q;
      logic     hot;
      logic     dry;
      logic     wet;
      if (w.valid_a) begin
        kept_temp[0] = w.temp_a;
        kept_hum[0]  = w.hum_a;
      end
      if (w.valid_b) begin
        kept_temp[1] = w.temp_b;
        kept_hum[1]  = w.hum_b;
      end
      tsum = int'(kept_temp[0]) + int'(kept_temp[1]);
      hsum = int'(kept_hum[0]) + int'(kept_hum[1]);
      r = '0;
      if (!regs.control_mode) begin
        hot = tsum > 2 * int'(regs.hot_limit);
        dry = hsum < 2 * int'(regs.dry_limit);
        wet = hsum > 2 * int'(regs.wet_limit);
        if (hot) begin
          r.fan_on        = 1'b1;
          r.humidifier_on = dry;
        end else if (dry) begin
          r.humidifier_on = 1'b1;
        end else if (!wet) begin
          r.fan_on = 1'b1;
        end else begin
          r.bulb_on = 1'b1;
        end
      end else begin
        r.fan_on        = regs.manual_fan;
        r.bulb_on       = regs.manual_bulb;
        r.humidifier_on = regs.manual_humidifier;
      end
      if (r.humidifier_on) begin
        // The error and integral are in half-percent steps.
        e = 2 * int'(regs.humidity_target) - hsum;
        integral = integral + e;
        if (integral > int'(INTEGRAL_MAX)) integral = int'(INTEGRAL_MAX);
        if (integral < 0) integral = 0;
        d = e - last_err;
        n = 20 * e + 2 * integral + d;
        if (n <= 0) begin
          duty = '0;
        end else begin
          q = (n * 1024) / 4000;
          duty = (q > int'(DUTY_FULL)) ? DUTY_FULL : q[10:0];
        end
        last_err = e;
        loop_runs++;
        if (duty == DUTY_FULL) full_duty++;
        if (duty == '0) zero_duty++;
      end
      r.duty_level = duty;
      r.tank_low   = (w.water_adc <= TANK_ALARM_CODE);
      r.temp_sum   = tsum[7:0];
      r.hum_sum    = hsum[7:0];
      if (r.tank_low) tank_alarms++;
      due.push_back(r);
    endfunction

    function void check_field(string name, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
        faults++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(czc_out_t got);
      czc_out_t want;
      if (due.size() == 0) begin
        faults++;
        $display("%0t: result word %h arrived with nothing expected", $time, got);
        return;
      end
      want = due.pop_front();
      checked++;
      check_field("fan_on", 11'(want.fan_on), 11'(got.fan_on));
      check_field("bulb_on", 11'(want.bulb_on), 11'(got.bulb_on));
      check_field("humidifier_on", 11'(want.humidifier_on), 11'(got.humidifier_on));
      check_field("duty_level", want.duty_level, got.duty_level);
      check_field("tank_low", 11'(want.tank_low), 11'(got.tank_low));
      check_field("temp_sum", 11'(want.temp_sum), 11'(got.temp_sum));
      check_field("hum_sum", 11'(want.hum_sum), 11'(got.hum_sum));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  czc_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  czc_out_t               out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  zone_outcome_book book;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_asks    = 0;
  int quiet_cycles = 0;
  int words_taken  = 0;

  climate_zone_controller_pid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_asks) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        book.take_sample(in_data);
        words_taken++;
      end
      if (out_valid && out_ready) book.match_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("climate_zone_controller_pid regression: fail");
        $finish;
      end
    end
  end

  task automatic send_word(czc_in_t w);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    book.set_reg(index, data);
    @(negedge clk);
  endtask

  function automatic logic [6:0] pick7();
    return ($urandom_range(99) < 85) ? 7'($urandom_range(100)) : 7'($urandom_range(127));
  endfunction

  task automatic configure(int phase);
    czc_cfg_t s;
    case (phase)
      0: s = {1'b0, HUMIDITY_TARGET_RESET, 3'b000, HOT_LIMIT_RESET, DRY_LIMIT_RESET,
              WET_LIMIT_RESET};
      1: s = {1'b0, 7'd127, 3'b000, 7'd0, 7'd127, 7'd127};
      2: s = {1'b0, 7'd0, 3'b111, 7'd127, 7'd0, 7'd0};
      3: s = {1'b1, 7'd100, 3'b111, 7'd100, 7'd100, 7'd100};
      4: s = {1'b1, 7'd127, 3'b000, 7'd0, 7'd0, 7'd0};
      5: s = {1'b1, 7'd0, 3'b001, 7'd63, 7'd64, 7'd0};
      default: begin
        s.control_mode      = 1'($urandom_range(1));
        s.humidity_target   = pick7();
        s.manual_fan        = 1'($urandom_range(1));
        s.manual_bulb       = 1'($urandom_range(1));
        s.manual_humidifier = 1'($urandom_range(1));
        s.hot_limit         = pick7();
        s.dry_limit         = pick7();
        s.wet_limit         = pick7();
      end
    endcase
    write_reg(CFG_CONTROL_MODE, {6'($urandom), s.control_mode});
    write_reg(CFG_HUMIDITY_TARGET, s.humidity_target);
    write_reg(CFG_MANUAL_FAN, {6'($urandom), s.manual_fan});
    write_reg(CFG_MANUAL_BULB, {6'($urandom), s.manual_bulb});
    write_reg(CFG_MANUAL_HUMIDIFIER, {6'($urandom), s.manual_humidifier});
    write_reg(CFG_HOT_LIMIT, s.hot_limit);
    write_reg(CFG_DRY_LIMIT, s.dry_limit);
    write_reg(CFG_WET_LIMIT, s.wet_limit);
    write_reg(CFG_INDEX_W'(CFG_WET_LIMIT + 1 + $urandom_range(7)), 7'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic czc_in_t mk(int ta, int tb, int ha, int hb, int va, int vb, int adc);
    czc_in_t w;
    w.temp_a    = 7'(ta);
    w.temp_b    = 7'(tb);
    w.hum_a     = 7'(ha);
    w.hum_b     = 7'(hb);
    w.valid_a   = 1'(va);
    w.valid_b   = 1'(vb);
    w.water_adc = 10'(adc);
    return w;
  endfunction

  function automatic logic [6:0] near(int centre, int spread);
    int x;
    x = centre + int'($urandom_range(2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 127) x = 127;
    return x[6:0];
  endfunction

  function automatic czc_in_t random_word();
    czc_in_t w;
    int      k;
    int      c;
    k = $urandom_range(9);
    if (k < 6) begin
      w.temp_a = near(int'(book.regs.hot_limit), 6);
      w.temp_b = near(int'(book.regs.hot_limit), 6);
    end else if (k < 9) begin
      w.temp_a = 7'($urandom_range(100));
      w.temp_b = 7'($urandom_range(100));
    end else begin
      w.temp_a = 7'($urandom_range(127));
      w.temp_b = 7'($urandom_range(127));
    end
    case ($urandom_range(2))
      0:       c = int'(book.regs.dry_limit);
      1:       c = int'(book.regs.wet_limit);
      default: c = int'(book.regs.humidity_target);
    endcase
    k = $urandom_range(9);
    if (k < 6) begin
      w.hum_a = near(c, 6);
      w.hum_b = near(c, 6);
    end else if (k < 9) begin
      w.hum_a = 7'($urandom_range(100));
      w.hum_b = 7'($urandom_range(100));
    end else begin
      w.hum_a = 7'($urandom_range(127));
      w.hum_b = 7'($urandom_range(127));
    end
    w.valid_a   = ($urandom_range(9) != 0);
    w.valid_b   = ($urandom_range(9) != 0);
    w.water_adc = ($urandom_range(9) < 4) ? 10'(283 + $urandom_range(6))
                                          : 10'($urandom_range(1023));
    return w;
  endfunction

  initial begin
    book      = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: hot above a sum of 80, dry below 140, wet above 160.
    send_word(mk(0, 0, 0, 0, 0, 0, 0));
    send_word(mk(0, 0, 0, 0, 1, 1, 0));
    send_word(mk(127, 127, 127, 127, 1, 1, 1023));
    send_word(mk(100, 100, 100, 100, 1, 1, 287));
    send_word(mk(41, 40, 69, 70, 1, 1, 286));
    send_word(mk(40, 40, 70, 70, 1, 1, 285));
    send_word(mk(40, 40, 80, 80, 1, 1, 300));
    send_word(mk(40, 40, 80, 81, 1, 1, 300));
    send_word(mk(60, 0, 30, 0, 1, 0, 512));
    send_word(mk(0, 60, 0, 30, 0, 1, 512));
    send_word(mk(5, 5, 100, 100, 0, 0, 1));
    repeat (6) send_word(mk(10, 10, 0, 0, 1, 1, 0));
    send_word(mk(10, 10, 127, 127, 1, 1, 700));
    send_word(mk(90, 90, 0, 0, 1, 1, 100));
    send_word(mk(90, 90, 75, 75, 1, 1, 100));
    send_word(mk(85, 42, 127, 0, 1, 1, 1022));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      configure(phase);
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_asks++;
        end
        1: begin
          idle_pct  = 54;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 54;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      repeat (WORDS_PER_PHASE) send_word(random_word());
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d result words against %0d input words under %0d register settings.",
             book.checked, words_taken, PHASES);
    $display("The duty loop ran on %0d words (%0d at full scale, %0d at zero); %0d low tank.",
             book.loop_runs, book.full_duty, book.zero_duty, book.tank_alarms);
    if (book.faults == 0 && book.due.size() == 0) begin
      $display("climate_zone_controller_pid regression: pass");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived", $time, book.faults,
               book.due.size());
      $display("climate_zone_controller_pid regression: fail");
    end
    $finish;
  end

endmodule

@@ climate_zone_controller_pid.f @@
+incdir+rtl/core
rtl/core/czc_pkg.sv
rtl/core/czc_cfg_regs.sv
rtl/core/czc_readings.sv
rtl/core/czc_decide.sv
rtl/core/czc_pid.sv
rtl/core/climate_zone_controller_pid.sv
rtl/core/czc_checker.sv
sim/tb_climate_zone_controller_pid.sv
